// ----- src/bds_pkg.sv -----
// ----------------------------------------------------------------------------
// bds_pkg: shared types and constants of the 2x2 box downsampler
// Channel widths, configuration register codes and reset values, and the
// per-pixel control word passed from the raster counters to the datapath, and pair_sum.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

  // Channel and sum widths
  localparam int CH_W   = 8;
  localparam int SUM_W  = CH_W + 1;     // sum of two samples
  localparam int PIX_W  = 3 * CH_W;     // packed {red, green, blue}
  localparam int PAIR_W = 3 * SUM_W;    // packed pair sums, blue in the low lane

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Default size limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // What one accepted pixel does
  typedef struct packed {
    logic hold_left;   // even column: capture as left pixel
    logic store_pair;  // even row, odd column: write pair sum to the line
    logic emit;        // odd row, odd column: produce one output
    logic frame_last;  // the emitted output closes the frame
  } pix_ctl_t;

  // Per-channel sum of two packed pixels, 9 bits a lane
  function automatic logic [PAIR_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PAIR_W-1:0] s;
    s = '0;
    for (int c = 0; c < 3; c++) begin
      s[c*SUM_W +: SUM_W] = SUM_W'(a[c*CH_W +: CH_W]) + SUM_W'(b[c*CH_W +: CH_W]);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/bds_line_mem.sv -----
// ----------------------------------------------------------------------------
// bds_line_mem: line store of horizontal pair sums
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_line_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 27
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered; data valid in the cycle after the read enable
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/bds_raster_pos.sv -----
// ----------------------------------------------------------------------------
// bds_raster_pos: raster position counters and pixel classification
// Tracks column and row of the next input pixel, clamps the configured frame
// size and tells the datapath what the current pixel does.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_raster_pos #(
  parameter int MAX_WIDTH  = bds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bds_pkg::MAX_HEIGHT_DEF,
  parameter int LAW        = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     advance,
  input  wire logic [bds_pkg::CFG_W-1:0] frame_width,
  input  wire logic [bds_pkg::CFG_W-1:0] frame_height,
  output bds_pkg::pix_ctl_t              ctl,
  output logic      [LAW-1:0]           line_idx
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] width_use, used_w;
  logic [HW-1:0] height_use, used_h;
  logic [WW:0]   col_ext, col_p1;
  logic [HW:0]   row_ext, row_p1;
  logic          in_frame;

  // Clamp the configured size to the supported range
  always_comb begin
    if (frame_width < bds_pkg::CFG_W'(2)) begin
      width_use = WW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_use = WW'(MAX_WIDTH);
    end else begin
      width_use = WW'(frame_width);
    end
    if (frame_height < bds_pkg::CFG_W'(2)) begin
      height_use = HW'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_use = HW'(MAX_HEIGHT);
    end else begin
      height_use = HW'(frame_height);
    end
  end

  // Drop a trailing odd column or row
  assign used_w  = {width_use[WW-1:1], 1'b0};
  assign used_h  = {height_use[HW-1:1], 1'b0};
  assign col_ext = (WW+1)'(col_r);
  assign row_ext = (HW+1)'(row_r);
  assign col_p1  = col_ext + (WW+1)'(1);
  assign row_p1  = row_ext + (HW+1)'(1);

  // Classify the current pixel
  assign in_frame = (col_ext < (WW+1)'(used_w)) && (row_ext < (HW+1)'(used_h));
  always_comb begin
    ctl.hold_left  = in_frame && !col_r[0];
    ctl.store_pair = in_frame && col_r[0] && !row_r[0];
    ctl.emit       = in_frame && col_r[0] && row_r[0];
    ctl.frame_last = ctl.emit && (col_p1 == (WW+1)'(used_w))
                              && (row_p1 == (HW+1)'(used_h));
  end

  assign line_idx = col_r[LAW:1];

  // Advance the position; wrap at row and frame end
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (col_p1 >= (WW+1)'(width_use)) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= (HW+1)'(height_use)) ? '0 : RW'(row_p1);
      end else begin
        col_nxt = CW'(col_p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/box_downsample_2x2_rgb.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2_rgb: streaming 2x2 box-filter downsampler
// Averages each 2x2 block of an RGB raster stream into one output pixel.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) takes one RGB pixel per transfer in
//   raster order. On even rows each odd column writes the horizontal pair
//   sum to a line store indexed by column/2; on odd rows each odd column
//   reads that entry back, adds the held left pixel and the current pixel
//   and sends the truncated mean on the output channel (out_valid/out_ready),
//   with out_frame_last on the last block of the frame. Trailing odd columns
//   and rows are consumed without output.
//   Throughput: one pixel per cycle while in_ready is high; each pixel issues
//   at most one line store read or write, at its input transfer. A pixel that
//   completes a block is registered in the read stage with its line store read,
//   then the sum goes into the output register. A stall on the output holds
//   the output register and the read stage; in_ready drops only when both are
//   full. The line store is written a row before it is read, so reads and
//   writes never meet on one entry. Reset clears the raster position, the held
//   left pixel, the pipeline valids and sets the frame size to 640 x 480; the
//   line store is not cleared. The user must write frame size on cfg_* only
//   while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x2_rgb #(
  parameter int MAX_WIDTH  = bds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bds_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bds_pkg::CFG_W-1:0]     cfg_data,
  // input pixels
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bds_pkg::CH_W-1:0]      in_red_in,
  input  wire logic [bds_pkg::CH_W-1:0]      in_green_in,
  input  wire logic [bds_pkg::CH_W-1:0]      in_blue_in,
  // output pixels
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bds_pkg::CH_W-1:0]      out_red_out,
  output logic      [bds_pkg::CH_W-1:0]      out_green_out,
  output logic      [bds_pkg::CH_W-1:0]      out_blue_out,
  output logic                              out_frame_last
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LAW        = $clog2(LINE_DEPTH);
  localparam int CH_W       = bds_pkg::CH_W;
  localparam int SUM_W      = bds_pkg::SUM_W;
  localparam int PIX_W      = bds_pkg::PIX_W;
  localparam int PAIR_W     = bds_pkg::PAIR_W;

  logic [bds_pkg::CFG_W-1:0] frame_width_r, frame_height_r;
  bds_pkg::pix_ctl_t         ctl;
  logic [LAW-1:0]            line_idx;
  logic [PIX_W-1:0]          cur_pix;
  logic [PIX_W-1:0]          held_left_r;
  logic [PAIR_W-1:0]         pre_sum;
  logic [PAIR_W-1:0]         line_rd_data;
  logic                      accept, out_free;
  logic                      s1_valid_r, s1_valid_nxt;
  logic [PAIR_W-1:0]         s1_pre_r;
  logic                      s1_last_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]          out_pix_r, out_pix_nxt;
  logic                      out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bds_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bds_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bds_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        bds_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: stall the input only when the read stage cannot drain
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_valid && in_ready;

  bds_raster_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LAW        (LAW)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .ctl          (ctl),
    .line_idx     (line_idx)
  );

  assign cur_pix = {in_red_in, in_green_in, in_blue_in};
  assign pre_sum = bds_pkg::pair_sum(held_left_r, cur_pix);

  // Hold the left pixel of each even-aligned pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_left_r <= '0;
    end else if (accept && ctl.hold_left) begin
      held_left_r <= cur_pix;
    end
  end

  bds_line_mem #(
    .DEPTH (LINE_DEPTH),
    .AW    (LAW),
    .DW    (PAIR_W)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept && ctl.store_pair),
    .wr_addr (line_idx),
    .wr_data (pre_sum),
    .rd_en   (accept && ctl.emit),
    .rd_addr (line_idx),
    .rd_data (line_rd_data)
  );

  // Read stage: carry the lower pair sum alongside the line read
  always_comb begin
    if (accept && ctl.emit) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctl.emit) begin
      s1_pre_r  <= pre_sum;
      s1_last_r <= ctl.frame_last;
    end
  end

  // Add upper and lower pair sums, divide by four per channel
  always_comb begin
    logic [SUM_W:0] s;
    out_pix_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      s = (SUM_W+1)'(line_rd_data[c*SUM_W +: SUM_W]) +
          (SUM_W+1)'(s1_pre_r[c*SUM_W +: SUM_W]);
      out_pix_nxt[c*CH_W +: CH_W] = s[SUM_W:2];
    end
  end

  // Output register
  assign out_valid_nxt = out_free ? s1_valid_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_pix_r  <= out_pix_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = out_pix_r[2*CH_W +: CH_W];
  assign out_green_out  = out_pix_r[CH_W +: CH_W];
  assign out_blue_out   = out_pix_r[0 +: CH_W];
  assign out_frame_last = out_last_r;

  // A stalled read stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_pre_r) && $stable(s1_last_r))
    else $error("read stage lost or changed an item under stall");

  // Every emitting transfer reaches the read stage
  a_emit_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl.emit |=> s1_valid_r)
    else $error("emitting pixel did not enter the read stage");

  // A pixel does at most one thing
  a_ctl_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.hold_left, ctl.store_pair, ctl.emit}))
    else $error("pixel classified more than one way");

  // Frame end marks only an emitted block
  a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.frame_last |-> ctl.emit)
    else $error("frame end flagged on a non-emitting pixel");

endmodule

`default_nettype wire
